[design/cdf_pkg.sv]
// Package: shared constants and types for the dead-zone follow camera.
`timescale 1ns / 1ps
package cdf_pkg;

	localparam int unsigned VIEW_WIDTH_DEF  = 320;
	localparam int unsigned VIEW_HEIGHT_DEF = 240;

	localparam int unsigned DEAD_ZONE     = 16;
	localparam int unsigned MAX_LAG       = 48;
	localparam int unsigned SETTLE_FRAMES = 30;

	localparam int unsigned COORD_W  = 32;
	localparam int unsigned SETTLE_W = 6;
	localparam int unsigned STEP_W   = 32;
	// wide enough for origin - half view - creep step and its differences
	localparam int unsigned CALC_W   = 36;

	localparam int unsigned APB_DW = 32;
	localparam int unsigned ADDR_W = 3;

	typedef enum logic [1:0] {
		CMD_FOLLOW   = 2'd0,
		CMD_SETUP    = 2'd1,
		CMD_TELEPORT = 2'd2
	} cmd_t;

	typedef enum logic [0:0] {
		REG_FROZEN = 1'b0
	} reg_idx_t;

endpackage

[design/cdf_if.sv]
// Interfaces: target input channel and view output channel.
`timescale 1ns / 1ps
interface cdf_in_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          command;
	logic signed [cdf_pkg::COORD_W-1:0]  aim_x;
	logic signed [cdf_pkg::COORD_W-1:0]  aim_y;

	modport source (output valid, command, aim_x, aim_y, input ready);
	modport sink (input valid, command, aim_x, aim_y, output ready);
endinterface

interface cdf_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [cdf_pkg::COORD_W-1:0]  view_x;
	logic signed [cdf_pkg::COORD_W-1:0]  view_y;

	modport source (output valid, view_x, view_y, input ready);
	modport sink (input valid, view_x, view_y, output ready);
endinterface

[design/camera_deadzone_follow.sv]
// Top level: dead-zone follow camera, input register, update logic, result register.
// An accepted word passes the input register and then the result register before it shows on the view channel.
// Throughput: one word per cycle while view.ready holds; the origin/counter update fits
// between the input register and the result register, so consecutive words chain directly.
// While a result waits on the output, the input register takes one more word, then stalls.
// Reset (arst_n low, asynchronous): origin, counters, frozen flag and valids clear.
`timescale 1ns / 1ps
module camera_deadzone_follow #(
	parameter int unsigned VIEW_WIDTH  = cdf_pkg::VIEW_WIDTH_DEF,
	parameter int unsigned VIEW_HEIGHT = cdf_pkg::VIEW_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	cdf_in_if.sink                            target,
	cdf_out_if.source                         view,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cdf_pkg::ADDR_W-1:0]        paddr,
	input  logic [cdf_pkg::APB_DW-1:0]        pwdata,
	output logic [cdf_pkg::APB_DW-1:0]        prdata,
	output logic                              pready
);

	localparam int unsigned CW = cdf_pkg::CALC_W;
	localparam int unsigned XW = cdf_pkg::COORD_W;
	localparam int unsigned SW = cdf_pkg::SETTLE_W;
	localparam int unsigned TW = cdf_pkg::STEP_W;

	localparam logic signed [CW-1:0] HALF_W = CW'(VIEW_WIDTH / 2);
	localparam logic signed [CW-1:0] HALF_H = CW'(VIEW_HEIGHT / 2);
	localparam logic signed [CW-1:0] DZ     = CW'(cdf_pkg::DEAD_ZONE);
	localparam logic signed [CW-1:0] LAG    = CW'(cdf_pkg::MAX_LAG);
	localparam logic signed [CW-1:0] MAX32  = CW'(64'sd2147483647);
	localparam logic signed [CW-1:0] MIN32  = CW'(-64'sd2147483648);
	localparam logic [SW-1:0]        SETTLE_LIM = SW'(cdf_pkg::SETTLE_FRAMES);

	function automatic logic signed [XW-1:0] sat32(input logic signed [CW-1:0] v);
		logic signed [XW-1:0] r;
		if (v > MAX32) begin
			r = MAX32[XW-1:0];
		end else if (v < MIN32) begin
			r = MIN32[XW-1:0];
		end else begin
			r = v[XW-1:0];
		end
		return r;
	endfunction

	// halve, truncating toward zero
	function automatic logic signed [CW-1:0] half_tz(input logic signed [CW-1:0] d);
		logic signed [CW-1:0] a;
		a = d + {{(CW-1){1'b0}}, d[CW-1]};
		return a >>> 1;
	endfunction

	// config register
	localparam int unsigned ADDR_HI = cdf_pkg::ADDR_W - 1;

	logic frozen_q;
	logic cfg_wr;
	logic cfg_hit;

	assign pready  = 1'b1;
	assign cfg_hit = (paddr[ADDR_HI:2] == cdf_pkg::REG_FROZEN);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = cfg_hit ? {{(cdf_pkg::APB_DW-1){1'b0}}, frozen_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frozen_q <= 1'b0;
		end else if (cfg_wr && cfg_hit) begin
			frozen_q <= pwdata[0];
		end
	end

	// pipeline registers
	logic                  v_s1;
	logic [1:0]            cmd_s1;
	logic signed [XW-1:0]  tx_s1;
	logic signed [XW-1:0]  ty_s1;
	logic                  v_s2;
	logic signed [XW-1:0]  vx_s2;
	logic signed [XW-1:0]  vy_s2;

	// camera state
	logic signed [XW-1:0]  ox_q;
	logic signed [XW-1:0]  oy_q;
	logic [SW-1:0]         settle_q;
	logic [TW-1:0]         step_q;

	logic in_acc;
	logic adv_s2;

	assign adv_s2       = v_s1 && (!v_s2 || view.ready);
	assign target.ready = !v_s1 || adv_s2;
	assign in_acc       = target.valid && target.ready;

	assign view.valid  = v_s2;
	assign view.view_x = vx_s2;
	assign view.view_y = vy_s2;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1 <= target.command;
			tx_s1  <= target.aim_x;
			ty_s1  <= target.aim_y;
		end
	end

	// update logic
	logic signed [CW-1:0]  ox_e, oy_e, xt, yt;
	logic signed [CW-1:0]  cx, cy0, cy1;
	logic signed [XW-1:0]  fx, fy, sx, sy;
	logic                  jump;
	logic [SW-1:0]         settle_f;
	logic [TW-1:0]         step_b, step_f;

	logic signed [XW-1:0]  ox_n, oy_n;
	logic [SW-1:0]         settle_n;
	logic [TW-1:0]         step_n;

	always_comb begin
		ox_e = CW'(ox_q);
		oy_e = CW'(oy_q);
		xt   = CW'(tx_s1) - HALF_W;
		yt   = CW'(ty_s1) - HALF_H;

		// horizontal dead zone
		if (xt > ox_e + DZ) begin
			cx = xt - DZ;
		end else if (xt < ox_e - DZ) begin
			cx = xt + DZ;
		end else begin
			cx = ox_e;
		end
		fx = sat32(ox_e + half_tz(cx - ox_e));

		// vertical: jump down, bounded lag, creep back
		jump = (yt > oy_e);
		if (jump) begin
			cy0      = yt;
			settle_f = '0;
			step_b   = '0;
		end else begin
			cy0      = (oy_e > yt + LAG) ? yt + LAG : oy_e;
			settle_f = (settle_q != '1) ? settle_q + SW'(1) : settle_q;
			step_b   = step_q;
		end

		cy1    = cy0;
		step_f = step_b;
		if (settle_f > SETTLE_LIM) begin
			cy1 = cy0 - CW'({1'b0, step_b});
			if (cy1 < yt) begin
				cy1 = yt;
			end
			step_f = (step_b != '1) ? step_b + TW'(1) : step_b;
		end
		fy = sat32(oy_e + half_tz(cy1 - oy_e));

		sx = sat32(xt);
		sy = sat32(yt);

		ox_n     = ox_q;
		oy_n     = oy_q;
		settle_n = settle_q;
		step_n   = step_q;
		case (cmd_s1)
			cdf_pkg::CMD_FOLLOW: begin
				if (!frozen_q) begin
					ox_n     = fx;
					oy_n     = fy;
					settle_n = settle_f;
					step_n   = step_f;
				end
			end
			cdf_pkg::CMD_SETUP: begin
				ox_n     = sx;
				oy_n     = sy;
				settle_n = '0;
				step_n   = '0;
			end
			cdf_pkg::CMD_TELEPORT: begin
				ox_n = sx;
				oy_n = sy;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			ox_q     <= '0;
			oy_q     <= '0;
			settle_q <= '0;
			step_q   <= '0;
		end else begin
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (adv_s2) begin
				v_s1 <= 1'b0;
			end
			if (adv_s2) begin
				v_s2     <= 1'b1;
				ox_q     <= ox_n;
				oy_q     <= oy_n;
				settle_q <= settle_n;
				step_q   <= step_n;
			end else if (view.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			vx_s2 <= ox_n;
			vy_s2 <= oy_n;
		end
	end

endmodule

[design/cdf_checker.sv]
// Checker: port-level assertions for the dead-zone follow camera, with bind.
`timescale 1ns / 1ps
module cdf_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [cdf_pkg::COORD_W-1:0]  out_x,
	input logic [cdf_pkg::COORD_W-1:0]  out_y,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [cdf_pkg::ADDR_W-1:0]   paddr,
	input logic [cdf_pkg::APB_DW-1:0]   pwdata,
	input logic [cdf_pkg::APB_DW-1:0]   prdata
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(out_y)))
		else $error("stalled result word changed");

	// input only backs up when a result is waiting
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// one word of buffering behind a stalled output, then input blocks
	a_one_deep: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && in_valid && in_ready) |=> (out_ready || !in_ready))
		else $error("input accepted beyond buffer depth");

	// frozen flag reads back what was written
	a_cfg_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && (paddr[cdf_pkg::ADDR_W-1:2] == cdf_pkg::REG_FROZEN))
		|=> ((paddr[cdf_pkg::ADDR_W-1:2] != cdf_pkg::REG_FROZEN) ||
		(prdata[0] == $past(pwdata[0]))))
		else $error("frozen register readback mismatch");

endmodule

bind camera_deadzone_follow cdf_checker u_cdf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (target.valid),
	.in_ready  (target.ready),
	.out_valid (view.valid),
	.out_ready (view.ready),
	.out_x     (view.view_x),
	.out_y     (view.view_y),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);
